/* rtl/jbhe_pkg.sv */
// ----------------------------------------------------------------------------
// jbhe_pkg
// Shared constants and helper functions for the JPEG block Huffman encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jbhe_pkg;

    localparam int AC_TABLE_DEPTH     = 256;
    localparam int DC_TABLE_DEPTH_DEF = 16;
    localparam int BLOCK_COEFS        = 64;

    localparam int POS_W   = $clog2(BLOCK_COEFS);
    localparam int AC_AW   = $clog2(AC_TABLE_DEPTH);
    localparam int LEN_W   = 5;
    localparam int CODE_W  = 16;
    localparam int ENTRY_W = LEN_W + CODE_W;
    localparam int COEF_W  = 12;
    localparam int SIZE_W  = 4;
    localparam int AMP_W   = 11;

    localparam logic [1:0] REQ_COEF  = 2'd0;
    localparam logic [1:0] REQ_DC_WR = 2'd1;
    localparam logic [1:0] REQ_AC_WR = 2'd2;

    localparam logic [AC_AW-1:0] SYM_ZRL = 8'hF0;
    localparam logic [AC_AW-1:0] SYM_EOB = 8'h00;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFS - 1);

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    typedef logic [ENTRY_W-1:0] entry_t;

    // Bit count of a magnitude
    function automatic logic [SIZE_W-1:0] size_of(input logic [AMP_W-1:0] mag);
        logic [SIZE_W-1:0] sz;
        sz = '0;
        for (int i = 0; i < AMP_W; i++) begin
            if (mag[i]) begin
                sz = SIZE_W'(i + 1);
            end
        end
        return sz;
    endfunction

    // Amplitude bits, one's complement for negative values
    function automatic logic [AMP_W-1:0] amplitude(input logic signed [COEF_W-1:0] v,
                                                   input logic [SIZE_W-1:0] sz);
        logic [COEF_W-1:0] mask;
        logic [COEF_W-1:0] vm1;
        mask = (COEF_W'(1) << sz) - COEF_W'(1);
        vm1  = v - COEF_W'(1);
        return v[COEF_W-1] ? (vm1[AMP_W-1:0] & mask[AMP_W-1:0]) : v[AMP_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/jpeg_block_huffman_encoder.sv */
// ----------------------------------------------------------------------------
// jpeg_block_huffman_encoder
// Baseline JPEG entropy coder for one 8x8 block of zigzag coefficients.
// ----------------------------------------------------------------------------
// Takes one item per cycle while s_tready is high: a coefficient or a DC/AC
// Huffman table write. Any item stalls while an earlier result is pending.
// Each coding result leaves through a registered output stage, one per cycle
// unless m_tready stalls it; a nonzero coefficient preceded by 16 or more
// zeros gets N ZRL results (N up to 3) ahead of its own. The code tables live
// in synchronous memories read at item accept; a write is visible to the very
// next coefficient item. Table entries must be written before use.
`default_nettype none

module jpeg_block_huffman_encoder #(
    parameter int DC_TABLE_DEPTH = jbhe_pkg::DC_TABLE_DEPTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // coefficient, dc_predictor, table_index, entry_length, entry_code
    input  wire logic [jbhe_pkg::IN_TDATA_W-1:0]    s_tdata,
    // req_type
    input  wire logic [1:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // code_length, code_bits, extra_length, extra_bits
    output logic [jbhe_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // code_missing
    output logic                                    m_tuser,
    output logic                                    m_tlast
);

    localparam int DC_AW = $clog2(DC_TABLE_DEPTH);

    logic signed [jbhe_pkg::COEF_W-1:0] s_coefficient;
    logic signed [jbhe_pkg::COEF_W-1:0] s_dc_predictor;
    logic [jbhe_pkg::AC_AW-1:0]         s_table_index;
    jbhe_pkg::entry_t                   s_entry;

    assign s_coefficient  = s_tdata[11:0];
    assign s_dc_predictor = s_tdata[23:12];
    assign s_table_index  = s_tdata[31:24];
    assign s_entry        = {s_tdata[36:32], s_tdata[52:37]};

    logic [jbhe_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [jbhe_pkg::POS_W-1:0] run_reg, run_next;

    jbhe_pkg::entry_t ac_mem [jbhe_pkg::AC_TABLE_DEPTH];
    jbhe_pkg::entry_t dc_mem [DC_TABLE_DEPTH];
    jbhe_pkg::entry_t ac_rd_reg;
    jbhe_pkg::entry_t dc_rd_reg;
    jbhe_pkg::entry_t zrl_entry_reg;

    logic                        b_valid_reg;
    logic                        b_dc_reg;
    logic [1:0]                  b_zrl_reg;
    logic [jbhe_pkg::SIZE_W-1:0] b_xlen_reg;
    logic [jbhe_pkg::AMP_W-1:0]  b_xbits_reg;

    logic m_tvalid_reg;
    logic [jbhe_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic m_tuser_reg;
    logic m_tlast_reg;

    logic accept;
    logic is_coef;
    logic signed [12:0]                 dc_diff;
    logic signed [jbhe_pkg::COEF_W-1:0] dc_sat;
    logic signed [jbhe_pkg::COEF_W-1:0] ac_sat;
    logic signed [jbhe_pkg::COEF_W-1:0] val;
    logic [jbhe_pkg::COEF_W-1:0]        val_abs;
    logic [jbhe_pkg::SIZE_W-1:0]        sz;
    logic [jbhe_pkg::AMP_W-1:0]         amp;
    logic                               emit;
    logic                               emit_dc;
    logic [1:0]                         emit_zrl;
    logic [jbhe_pkg::AC_AW-1:0]         sym;

    logic out_load;
    logic b_done;
    jbhe_pkg::entry_t cur_entry;
    logic [jbhe_pkg::LEN_W-1:0]  cur_len;
    logic [jbhe_pkg::CODE_W-1:0] cur_code;
    logic [jbhe_pkg::SIZE_W-1:0] cur_xlen;
    logic [jbhe_pkg::AMP_W-1:0]  cur_xbits;
    logic                        cur_last;

    assign accept  = s_tvalid && s_tready;
    assign is_coef = (s_tuser == jbhe_pkg::REQ_COEF);

    // Value classification and symbol formation
    always_comb begin
        dc_diff = 13'({s_coefficient[11], s_coefficient})
                - 13'({s_dc_predictor[11], s_dc_predictor});
        if (dc_diff > 13'sd2047) begin
            dc_sat = 12'sd2047;
        end else if (dc_diff < -13'sd2047) begin
            dc_sat = -12'sd2047;
        end else begin
            dc_sat = dc_diff[11:0];
        end
        ac_sat  = (s_coefficient == -12'sd2048) ? -12'sd2047 : s_coefficient;
        val     = (pos_reg == '0) ? dc_sat : ac_sat;
        val_abs = val[11] ? 12'(-val) : 12'(val);
        sz      = jbhe_pkg::size_of(val_abs[jbhe_pkg::AMP_W-1:0]);
        amp     = jbhe_pkg::amplitude(val, sz);

        emit     = 1'b0;
        emit_dc  = 1'b0;
        emit_zrl = 2'd0;
        sym      = {run_reg[3:0], sz};
        run_next = run_reg;
        if (pos_reg == '0) begin
            emit     = 1'b1;
            emit_dc  = 1'b1;
            run_next = '0;
        end else if (val == '0) begin
            run_next = run_reg + 1'b1;
            if (pos_reg == jbhe_pkg::LAST_POS) begin
                emit = 1'b1;
                sym  = jbhe_pkg::SYM_EOB;
            end
        end else begin
            emit     = 1'b1;
            emit_zrl = run_reg[5:4];
            run_next = '0;
        end
        if (pos_reg == jbhe_pkg::LAST_POS) begin
            pos_next = '0;
            run_next = '0;
        end else begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // Code tables
    always_ff @(posedge aclk) begin
        if (accept && s_tuser == jbhe_pkg::REQ_AC_WR) begin
            ac_mem[s_table_index] <= s_entry;
        end
        if (accept && s_tuser == jbhe_pkg::REQ_DC_WR && s_table_index < DC_TABLE_DEPTH) begin
            dc_mem[s_table_index[DC_AW-1:0]] <= s_entry;
        end
        if (accept && is_coef) begin
            ac_rd_reg <= ac_mem[sym];
            dc_rd_reg <= dc_mem[sz[DC_AW-1:0]];
        end
    end

    // Shadow copy of the ZRL entry
    always_ff @(posedge aclk) begin
        if (accept && s_tuser == jbhe_pkg::REQ_AC_WR && s_table_index == jbhe_pkg::SYM_ZRL) begin
            zrl_entry_reg <= s_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            run_reg <= '0;
        end else if (accept && is_coef) begin
            pos_reg <= pos_next;
            run_reg <= run_next;
        end
    end

    // Result sequencing
    assign out_load = b_valid_reg && (!m_tvalid_reg || m_tready);
    assign b_done   = out_load && (b_zrl_reg == 2'd0);
    assign s_tready = !b_valid_reg || b_done;

    always_comb begin
        if (b_zrl_reg != 2'd0) begin
            cur_entry = zrl_entry_reg;
        end else if (b_dc_reg) begin
            cur_entry = dc_rd_reg;
        end else begin
            cur_entry = ac_rd_reg;
        end
        cur_len   = cur_entry[jbhe_pkg::ENTRY_W-1:jbhe_pkg::CODE_W];
        cur_code  = (cur_len != '0) ? cur_entry[jbhe_pkg::CODE_W-1:0] : '0;
        cur_last  = (b_zrl_reg == 2'd0);
        cur_xlen  = cur_last ? b_xlen_reg : '0;
        cur_xbits = cur_last ? b_xbits_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (accept && is_coef && emit) begin
            b_valid_reg <= 1'b1;
        end else if (b_done) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_coef && emit) begin
            b_dc_reg    <= emit_dc;
            b_zrl_reg   <= emit_zrl;
            b_xlen_reg  <= sz;
            b_xbits_reg <= amp;
        end else if (out_load && b_zrl_reg != 2'd0) begin
            b_zrl_reg <= b_zrl_reg - 2'd1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'd0, cur_xbits, cur_xlen, cur_code, cur_len};
            m_tuser_reg <= (cur_len == '0);
            m_tlast_reg <= cur_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

/* rtl/jbhe_checker.sv */
// ----------------------------------------------------------------------------
// jbhe_checker
// Port-level checks for the JPEG block Huffman encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module jbhe_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic [jbhe_pkg::IN_TDATA_W-1:0]     s_tdata,
    input wire logic [1:0]                          s_tuser,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [jbhe_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input wire logic                                m_tuser,
    input wire logic                                m_tlast
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input item changed while stalled");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_missing_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata[4:0] == 5'd0))
                     && (!m_tuser || m_tdata[20:5] == 16'd0))
        else $error("code_missing disagrees with code_length or code bits");

    a_extra_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[24:21] == 4'd0) |-> (m_tdata[35:25] == 11'd0))
        else $error("amplitude bits without amplitude length");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind jpeg_block_huffman_encoder jbhe_checker u_jbhe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
